/* sv/mmbp_pkg.sv */
// ----------------------------------------------------------------------------
// mmbp_pkg
// Sizes and address helper for the min/max bound pyramid.
// ----------------------------------------------------------------------------
package mmbp_pkg;

  localparam int LOG_SIZE   = 6;
  localparam int SAMPLE_W   = 16;
  localparam int BASE_CELLS = 1 << (2 * LOG_SIZE);
  localparam int PYR_CELLS  = (BASE_CELLS - 1) / 3;
  localparam int BASE_W     = 2 * LOG_SIZE;
  localparam int IDX_W      = $clog2(PYR_CELLS + 1);
  localparam int LEVEL_W    = 3;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;
  localparam logic BOUND_MIN = 1'b0;
  localparam logic BOUND_MAX = 1'b1;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_TOP    = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_BOTTOM = {1'b1, {(SAMPLE_W-1){1'b0}}};

  // Flat pyramid index of the level-lv cell that covers base cell (x, y).
  // Level offset (4^lv - 1) / 3 is a sum of distinct powers of four.
  function automatic logic [IDX_W-1:0] pyr_addr(
    input logic [LOG_SIZE-1:0] x,
    input logic [LOG_SIZE-1:0] y,
    input logic [LEVEL_W-1:0]  lv
  );
    logic [IDX_W-1:0]    off;
    logic [IDX_W-1:0]    pos;
    logic [LOG_SIZE-1:0] cx;
    logic [LOG_SIZE-1:0] cy;
    off = '0;
    for (int k = 0; k < LOG_SIZE; k++) begin
      if (k < int'(lv)) begin
        off[2*k] = 1'b1;
      end
    end
    cx  = x >> (LOG_SIZE - int'(lv));
    cy  = y >> (LOG_SIZE - int'(lv));
    pos = (IDX_W'(cy) << lv) | IDX_W'(cx);
    return off + pos;
  endfunction

endpackage

/* sv/min_max_bound_pyramid.sv */
// ----------------------------------------------------------------------------
// min_max_bound_pyramid
// Base height map plus a min/max pyramid; writes update every level,
// queries return the bound of the covering cell or the base sample.
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------------------
//  item     | item_valid, item_stall | cmd, col, row, sample, level, which_bound
//  bound    | bound_valid, bound_stall | bound_value
//
//  Write: one read-modify-write per level through the single read and write
//  port of the min and max memories.
//  Query: memory read, then output register.
//  After reset a clearing pass over all PYR_CELLS cells fills both stores.
//  A waiting result does not block a following write transaction.
module min_max_bound_pyramid (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  item_valid,
  output logic                                  item_stall,
  input  logic                                  cmd,
  input  logic [mmbp_pkg::LOG_SIZE-1:0]         col,
  input  logic [mmbp_pkg::LOG_SIZE-1:0]         row,
  input  logic signed [mmbp_pkg::SAMPLE_W-1:0]  sample,
  input  logic [mmbp_pkg::LEVEL_W-1:0]          level,
  input  logic                                  which_bound,
  output logic                                  bound_valid,
  input  logic                                  bound_stall,
  output logic signed [mmbp_pkg::SAMPLE_W-1:0]  bound_value
);

  localparam logic [1:0] S_CLEAR  = 2'd0;
  localparam logic [1:0] S_IDLE   = 2'd1;
  localparam logic [1:0] S_UPDATE = 2'd2;
  localparam logic [1:0] S_QUERY  = 2'd3;

  localparam logic CMD_WRITE = mmbp_pkg::CMD_WRITE;

  localparam logic [mmbp_pkg::LEVEL_W-1:0] TOP_LEVEL =
    mmbp_pkg::LEVEL_W'(mmbp_pkg::LOG_SIZE);
  localparam logic [mmbp_pkg::LEVEL_W-1:0] LAST_LEVEL =
    mmbp_pkg::LEVEL_W'(mmbp_pkg::LOG_SIZE - 1);
  localparam logic [mmbp_pkg::IDX_W-1:0] LAST_CELL =
    mmbp_pkg::IDX_W'(mmbp_pkg::PYR_CELLS - 1);

  logic signed [mmbp_pkg::SAMPLE_W-1:0] base_mem [mmbp_pkg::BASE_CELLS];
  logic signed [mmbp_pkg::SAMPLE_W-1:0] min_mem  [mmbp_pkg::PYR_CELLS];
  logic signed [mmbp_pkg::SAMPLE_W-1:0] max_mem  [mmbp_pkg::PYR_CELLS];

  logic [1:0]                           state;
  logic [mmbp_pkg::IDX_W-1:0]           clr_cnt;
  logic [mmbp_pkg::LEVEL_W-1:0]         lvl;
  logic [mmbp_pkg::LOG_SIZE-1:0]        x_r;
  logic [mmbp_pkg::LOG_SIZE-1:0]        y_r;
  logic signed [mmbp_pkg::SAMPLE_W-1:0] s_r;
  logic                                 q_base;
  logic                                 q_which;
  logic [mmbp_pkg::IDX_W-1:0]           upd_addr;

  logic signed [mmbp_pkg::SAMPLE_W-1:0] rd_min;
  logic signed [mmbp_pkg::SAMPLE_W-1:0] rd_max;
  logic signed [mmbp_pkg::SAMPLE_W-1:0] rd_base;

  logic                                 accept;
  logic                                 is_base;
  logic [mmbp_pkg::LEVEL_W-1:0]         q_level;
  logic [mmbp_pkg::BASE_W-1:0]          base_addr;
  logic                                 rd_en;
  logic [mmbp_pkg::IDX_W-1:0]           rd_addr;
  logic                                 wr_en;
  logic [mmbp_pkg::IDX_W-1:0]           wr_addr;
  logic signed [mmbp_pkg::SAMPLE_W-1:0] wr_min;
  logic signed [mmbp_pkg::SAMPLE_W-1:0] wr_max;
  logic                                 out_load;

  assign item_stall = (state != S_IDLE);
  assign accept     = item_valid && !item_stall;
  assign is_base    = (level >= TOP_LEVEL);
  assign q_level    = is_base ? '0 : level;
  assign base_addr  = {row, col};
  assign out_load   = (state == S_QUERY) && (!bound_valid || !bound_stall);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = upd_addr;
    wr_min  = (s_r < rd_min) ? s_r : rd_min;
    wr_max  = (s_r > rd_max) ? s_r : rd_max;
    unique case (state)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_cnt;
        wr_min  = mmbp_pkg::SAMPLE_TOP;
        wr_max  = mmbp_pkg::SAMPLE_BOTTOM;
      end
      S_IDLE: begin
        rd_en   = accept;
        rd_addr = mmbp_pkg::pyr_addr(col, row, (cmd == CMD_WRITE) ? '0 : q_level);
      end
      S_UPDATE: begin
        wr_en   = 1'b1;
        rd_en   = (lvl != LAST_LEVEL);
        rd_addr = mmbp_pkg::pyr_addr(x_r, y_r, lvl + 1'b1);
      end
      S_QUERY: begin
      end
      default: begin
      end
    endcase
  end

  // pyramid stores: one read and one write port each
  always_ff @(posedge clk) begin
    if (wr_en) begin
      min_mem[wr_addr] <= wr_min;
      max_mem[wr_addr] <= wr_max;
    end
    if (rd_en) begin
      rd_min <= min_mem[rd_addr];
      rd_max <= max_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (accept && cmd == CMD_WRITE) begin
      base_mem[base_addr] <= sample;
    end
    if (accept && cmd != CMD_WRITE) begin
      rd_base <= base_mem[base_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
      lvl     <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == LAST_CELL) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          lvl <= '0;
          if (accept) begin
            state <= (cmd == CMD_WRITE) ? S_UPDATE : S_QUERY;
          end
        end
        S_UPDATE: begin
          lvl <= lvl + 1'b1;
          if (lvl == LAST_LEVEL) begin
            state <= S_IDLE;
          end
        end
        S_QUERY: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // transaction fields held for the update sweep and the query
  always_ff @(posedge clk) begin
    if (accept) begin
      x_r     <= col;
      y_r     <= row;
      s_r     <= sample;
      q_base  <= is_base;
      q_which <= which_bound;
    end
    if (rd_en) begin
      upd_addr <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bound_valid <= 1'b0;
    end else if (out_load) begin
      bound_valid <= 1'b1;
    end else if (!bound_stall) begin
      bound_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      bound_value <= q_base ? rd_base
                            : ((q_which == mmbp_pkg::BOUND_MAX) ? rd_max : rd_min);
    end
  end

endmodule

/* tb/tb_min_max_bound_pyramid.sv */
// ----------------------------------------------------------------------------
// tb_min_max_bound_pyramid
// Self-checking bench for the min/max bound pyramid. A scoreboard keeps its
// own base map and per-level min/max grids, predicts each query result as a
// transaction is accepted, and checks bound results in order. The stimulus
// starts with a directed set: reset bounds, extreme samples, every level and
// the base map. A random mix follows, with half of its writes in a hot window.
// Random gaps are applied on the item side and random stalls on the bound side.
// ----------------------------------------------------------------------------
module tb_min_max_bound_pyramid;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LS    = mmbp_pkg::LOG_SIZE;
  localparam int SW    = mmbp_pkg::SAMPLE_W;
  localparam int CELLS = mmbp_pkg::BASE_CELLS;
  localparam int LIMIT = 300000;
  localparam int RANDOM_ITEMS = 400;

  localparam bit CMD_WRITE = mmbp_pkg::CMD_WRITE;
  localparam bit CMD_QUERY = mmbp_pkg::CMD_QUERY;
  localparam bit BOUND_MIN = mmbp_pkg::BOUND_MIN;
  localparam bit BOUND_MAX = mmbp_pkg::BOUND_MAX;

  logic                         clk;
  logic                         rst;
  logic                         item_valid;
  logic                         item_stall;
  logic                         cmd;
  logic [LS-1:0]                col;
  logic [LS-1:0]                row;
  logic signed [SW-1:0]         sample;
  logic [mmbp_pkg::LEVEL_W-1:0] level;
  logic                         which_bound;
  logic                         bound_valid;
  logic                         bound_stall;
  logic signed [SW-1:0]         bound_value;

  class bound_scoreboard;
    logic signed [SW-1:0] base_val [CELLS];
    logic signed [SW-1:0] grid_min [LS][CELLS];
    logic signed [SW-1:0] grid_max [LS][CELLS];
    logic signed [SW-1:0] expected_bounds [$];
    int errors;
    int checked;

    function new();
      for (int c = 0; c < CELLS; c++) begin
        base_val[c] = '0;
        for (int l = 0; l < LS; l++) begin
          grid_min[l][c] = mmbp_pkg::SAMPLE_TOP;
          grid_max[l][c] = mmbp_pkg::SAMPLE_BOTTOM;
        end
      end
      errors  = 0;
      checked = 0;
    endfunction

    function void note_item(bit c, bit [LS-1:0] x, bit [LS-1:0] y,
                            logic signed [SW-1:0] s, bit [2:0] lv, bit w);
      int base_idx;
      int idx;
      base_idx = (int'(y) << LS) | int'(x);
      if (c == CMD_WRITE) begin
        base_val[base_idx] = s;
        for (int l = 0; l < LS; l++) begin
          idx = ((int'(y) >> (LS - l)) << l) | (int'(x) >> (LS - l));
          if (s < grid_min[l][idx]) grid_min[l][idx] = s;
          if (s > grid_max[l][idx]) grid_max[l][idx] = s;
        end
      end else if (lv >= LS) begin
        expected_bounds.push_back(base_val[base_idx]);
      end else begin
        idx = ((int'(y) >> (LS - lv)) << lv) | (int'(x) >> (LS - lv));
        expected_bounds.push_back(w == BOUND_MAX ? grid_max[lv][idx] : grid_min[lv][idx]);
      end
    endfunction

    function void check_bound(logic signed [SW-1:0] got);
      logic signed [SW-1:0] want;
      if (expected_bounds.size() == 0) begin
        $display("%0t: unexpected bound result, expected none, got %0d", $time, got);
        errors++;
      end else begin
        want = expected_bounds.pop_front();
        checked++;
        if (got !== want) begin
          $display("%0t: bound_value mismatch, expected %0d, got %0d", $time, want, got);
          errors++;
        end
      end
    endfunction

    function int pending();
      return expected_bounds.size();
    endfunction
  endclass

  bound_scoreboard sb;
  int  written_cells [$];
  bit  written_map [CELLS];
  int  n_writes;
  int  n_queries;
  int  burst_left;
  int  cycle_count;
  int  stall_left;

  min_max_bound_pyramid dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .cmd         (cmd),
    .col         (col),
    .row         (row),
    .sample      (sample),
    .level       (level),
    .which_bound (which_bound),
    .bound_valid (bound_valid),
    .bound_stall (bound_stall),
    .bound_value (bound_value)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // stall runs: mostly short, some long, free runs give stall-free stretches
  always @(posedge clk) begin
    if (rst) begin
      bound_stall <= 1'b0;
      stall_left  <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else begin
      bound_stall <= ($urandom_range(0, 2) == 0);
      stall_left  <= ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40)
                                                 : $urandom_range(0, 3);
    end
  end

  always @(posedge clk) begin
    if (!rst && bound_valid && !bound_stall) sb.check_bound(bound_value);
  end

  function automatic int pick_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) burst_left = $urandom_range(15, 30);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_item(input bit c, input int x, input int y,
                           input logic signed [SW-1:0] s, input int lv,
                           input bit w);
    int gap;
    int cell_idx;
    item_valid  <= 1'b1;
    cmd         <= c;
    col         <= LS'(x);
    row         <= LS'(y);
    sample      <= s;
    level       <= mmbp_pkg::LEVEL_W'(lv);
    which_bound <= w;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    sb.note_item(c, LS'(x), LS'(y), s, 3'(lv), w);
    cell_idx = (y << LS) | x;
    if (c == CMD_WRITE) begin
      n_writes++;
      if (!written_map[cell_idx]) begin
        written_map[cell_idx] = 1'b1;
        written_cells.push_back(cell_idx);
      end
    end else begin
      n_queries++;
    end
    gap = pick_gap();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_random();
    bit [LS-1:0] x;
    bit [LS-1:0] y;
    bit [2:0]    lv;
    int          cell_idx;
    x  = LS'($urandom);
    y  = LS'($urandom);
    lv = 3'($urandom);
    if ($urandom_range(0, 99) < 45) begin
      if ($urandom_range(0, 1) == 0) begin
        x = LS'(24 + $urandom_range(0, 7));
        y = LS'(16 + $urandom_range(0, 7));
      end
      send_item(CMD_WRITE, int'(x), int'(y), SW'($urandom), int'(lv), 1'($urandom));
    end else begin
      if (lv >= LS || $urandom_range(0, 2) == 0) begin
        cell_idx = written_cells[$urandom_range(0, written_cells.size() - 1)];
        x = cell_idx[LS-1:0];
        y = cell_idx[2*LS-1:LS];
      end
      send_item(CMD_QUERY, int'(x), int'(y), SW'($urandom), int'(lv), 1'($urandom));
    end
  endtask

  initial begin
    sb          = new();
    n_writes    = 0;
    n_queries   = 0;
    burst_left  = 0;
    cycle_count = 0;
    rst         <= 1'b1;
    item_valid  <= 1'b0;
    cmd         <= CMD_WRITE;
    col         <= '0;
    row         <= '0;
    sample      <= '0;
    level       <= '0;
    which_bound <= BOUND_MIN;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // untouched cells report reset bounds
    send_item(CMD_QUERY, 0, 0, 16'sh7fff, 0, BOUND_MIN);
    send_item(CMD_QUERY, 63, 63, 16'sh0000, 5, BOUND_MAX);
    // extreme and small samples in the corners; level and which_bound ignored on writes
    send_item(CMD_WRITE, 0, 0, 16'sh7fff, 7, BOUND_MAX);
    send_item(CMD_WRITE, 63, 63, 16'sh8000, 0, BOUND_MIN);
    send_item(CMD_WRITE, 63, 0, 16'sh0000, 6, BOUND_MAX);
    send_item(CMD_WRITE, 0, 63, 16'shffff, 3, BOUND_MIN);
    send_item(CMD_QUERY, 10, 20, 16'shffff, 0, BOUND_MIN);
    send_item(CMD_QUERY, 10, 20, 16'sh8000, 0, BOUND_MAX);
    send_item(CMD_QUERY, 63, 63, 16'sh1234, 1, BOUND_MIN);
    send_item(CMD_QUERY, 0, 0, 16'sh0000, 1, BOUND_MAX);
    send_item(CMD_QUERY, 0, 63, 16'sh0000, 5, BOUND_MIN);
    send_item(CMD_QUERY, 63, 0, 16'sh0000, 3, BOUND_MAX);
    send_item(CMD_QUERY, 0, 0, 16'sh0000, 6, BOUND_MAX);
    send_item(CMD_QUERY, 63, 63, 16'sh0000, 7, BOUND_MIN);
    // overwrite: base follows, pyramid keeps earlier extremes
    send_item(CMD_WRITE, 0, 0, -16'sd5, 2, BOUND_MIN);
    send_item(CMD_QUERY, 0, 0, 16'sh0000, 6, BOUND_MIN);
    send_item(CMD_QUERY, 0, 0, 16'sh0000, 5, BOUND_MAX);
    send_item(CMD_QUERY, 1, 1, 16'sh0000, 5, BOUND_MIN);
    send_item(CMD_QUERY, 32, 32, 16'sh0000, 4, BOUND_MIN);
    send_item(CMD_QUERY, 32, 32, 16'sh0000, 2, BOUND_MAX);
    send_item(CMD_QUERY, 5, 60, 16'sh0000, 4, BOUND_MAX);

    for (int n = 0; n < RANDOM_ITEMS; n++) send_random();
    item_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("%0d writes and %0d queries sent, %0d bound results checked",
             n_writes, n_queries, sb.checked);
    $display("%0d distinct base cells written, queries over levels 0 to 7",
             written_cells.size());
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/mmbp_pkg.sv
sv/min_max_bound_pyramid.sv
tb/tb_min_max_bound_pyramid.sv
